// File: rtl/core/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, constants and helpers for the peer consensus fusion block.
// ----------------------------------------------------------------------------
package pcf_pkg;

   localparam int MAX_PEERS_DEF = 8;

   localparam int FRAC_W   = 16;
   localparam int ATT_W    = 17;
   localparam int HEIGHT_W = 12;
   localparam int SLOT_W   = 3;
   localparam int COUNT_W  = 4;
   localparam int ORIGIN_W = 11;

   localparam int LANES  = 3;
   localparam int LANE_W = $clog2(LANES);

   localparam int QUEUE_DEPTH = 2;

   localparam logic [FRAC_W-1:0]   ONE_Q15       = 16'd32768;
   localparam int                  WEIGHT_W      = 17;
   localparam logic [WEIGHT_W-1:0] HALF_Q15      = 17'd16384;
   localparam int                  PROD_W        = WEIGHT_W + HEIGHT_W;
   localparam logic [ORIGIN_W-1:0] ORIGIN_MAX_MM = 11'd2000;

   // serial divider: quotient bits retired one per cycle
   localparam int QUOT_W     = 16;
   localparam int DEN_MEAN_W = 5;

   // blend: (pct*local + (100-pct)*mean) / 100 via reciprocal multiply
   localparam int                 PCT_W       = 7;
   localparam int                 BLEND_W     = 22;
   localparam int                 RECIP_W     = 23;
   localparam int                 RECIP_SHIFT = 29;
   localparam int                 SCALE_W     = BLEND_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_100   = 23'd5368710;
   localparam logic [PCT_W-1:0]   PCT_TOTAL   = 7'd100;

   typedef logic [PCT_W-1:0] pct_type;
   localparam pct_type PCT_LOCAL [LANES] = '{7'd62, 7'd60, 7'd55};

   // CSR map
   localparam int                 CSR_ADDR_W        = 3;
   localparam logic               CSR_PEERS_IN_USE  = 1'b0;
   localparam logic [COUNT_W-1:0] PEERS_IN_USE_RST  = 4'd4;

   typedef enum logic {
      KIND_PEER = 1'b0,
      KIND_MEAS = 1'b1
   } kind_type;

   // lane order in frac: leak, spread, confidence
   typedef struct packed {
      kind_type                       kind;
      logic [SLOT_W-1:0]              slot;
      logic [LANES-1:0][FRAC_W-1:0]   frac;
      logic signed [ATT_W-1:0]        att;
      logic [HEIGHT_W-1:0]            height;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIVIDE,
      ST_NUMER,
      ST_SCALE,
      ST_OUTPUT
   } state_type;

   function automatic logic [FRAC_W-1:0] sat_frac(input logic [FRAC_W-1:0] v);
      return (v > ONE_Q15) ? ONE_Q15 : v;
   endfunction

endpackage

// File: rtl/core/pcf_front.sv
// ----------------------------------------------------------------------------
// pcf_front
// Takes request beats, saturates fractions, tags the item kind and holds
// items in a short queue for the back end.
// ----------------------------------------------------------------------------
module pcf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic                              req_kind,
   input  logic [pcf_pkg::SLOT_W-1:0]        req_slot,
   input  logic [pcf_pkg::FRAC_W-1:0]        req_leak_level,
   input  logic [pcf_pkg::FRAC_W-1:0]        req_spread_level,
   input  logic [pcf_pkg::FRAC_W-1:0]        req_confidence_level,
   input  logic signed [pcf_pkg::ATT_W-1:0]  req_attenuation,
   input  logic [pcf_pkg::HEIGHT_W-1:0]      req_height_mm,
   output pcf_pkg::item_type                 q_item,
   output logic                              q_valid,
   input  logic                              q_pop
);
   import pcf_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   item_type          in_item;
   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      in_item.kind    = kind_type'(req_kind);
      in_item.slot    = req_slot;
      in_item.frac[0] = sat_frac(req_leak_level);
      in_item.frac[1] = sat_frac(req_spread_level);
      in_item.frac[2] = sat_frac(req_confidence_level);
      in_item.att     = req_attenuation;
      in_item.height  = req_height_mm;
   end

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = q_pop & q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: rtl/core/pcf_div.sv
// ----------------------------------------------------------------------------
// pcf_div
// Restoring divider, one quotient bit per step. The quotient must fit in
// QUOT_W bits, so the remainder starts from the dividend's upper part.
// ----------------------------------------------------------------------------
module pcf_div #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 5
) (
   input  logic                        clock,
   input  logic                        start,
   input  logic                        step,
   input  logic [NUM_W-1:0]            numer,
   input  logic [DEN_W-1:0]            denom,
   output logic [pcf_pkg::QUOT_W-1:0]  quot
);
   import pcf_pkg::*;

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [DEN_W:0]    trial;
   logic              ge;

   assign trial = {rem_ff, q_ff[QUOT_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      q_in   = q_ff;
      if (start) begin
         rem_in = DEN_W'(numer >> QUOT_W);
         den_in = denom;
         q_in   = numer[QUOT_W-1:0];
      end else if (step) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         q_in   = {q_ff[QUOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign quot = q_ff;

endmodule

// File: rtl/core/pcf_back.sv
// ----------------------------------------------------------------------------
// pcf_back
// Owns the peer table. Applies peer reports, and for a measurement walks
// the peers, divides serially, blends and registers the result beat.
// ----------------------------------------------------------------------------
module pcf_back #(
   parameter int MAX_PEERS = pcf_pkg::MAX_PEERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pcf_pkg::item_type                 q_item,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  logic [pcf_pkg::COUNT_W-1:0]       peers_in_use,
   input  logic                              pop,
   output logic                              empty,
   output logic [pcf_pkg::COUNT_W-1:0]       rsp_peers_used,
   output logic [pcf_pkg::ORIGIN_W-1:0]      rsp_origin_mm,
   output logic signed [pcf_pkg::ATT_W-1:0]  rsp_first_peer_attenuation,
   output logic [pcf_pkg::FRAC_W-1:0]        rsp_fused_leak,
   output logic [pcf_pkg::FRAC_W-1:0]        rsp_fused_spread,
   output logic [pcf_pkg::FRAC_W-1:0]        rsp_fused_confidence,
   output logic [pcf_pkg::FRAC_W-1:0]        rsp_mean_leak,
   output logic [pcf_pkg::FRAC_W-1:0]        rsp_mean_spread,
   output logic [pcf_pkg::FRAC_W-1:0]        rsp_mean_confidence
);
   import pcf_pkg::*;

   localparam int IDX_W  = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CW     = $clog2(MAX_PEERS + 1);
   localparam int SUM_W  = FRAC_W + CW;
   localparam int HSUM_W = PROD_W + CW;
   localparam int WSUM_W = WEIGHT_W + CW;
   localparam int STEP_W = $clog2(QUOT_W);

   typedef logic [LANES-1:0][FRAC_W-1:0] frac_set_type;

   state_type state_ff, state_in;

   frac_set_type            tab_frac_ff [MAX_PEERS];
   frac_set_type            tab_frac_in [MAX_PEERS];
   logic signed [ATT_W-1:0] tab_att_ff  [MAX_PEERS];
   logic signed [ATT_W-1:0] tab_att_in  [MAX_PEERS];
   logic [HEIGHT_W-1:0]     tab_hgt_ff  [MAX_PEERS];
   logic [HEIGHT_W-1:0]     tab_hgt_in  [MAX_PEERS];

   logic [COUNT_W-1:0]      n_ff, n_in, n_calc;
   logic [COUNT_W-1:0]      cnt_ff, cnt_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [LANE_W-1:0]       lane_ff, lane_in;
   logic [FRAC_W-1:0]       loc_ff   [LANES];
   logic [FRAC_W-1:0]       loc_in   [LANES];
   logic [SUM_W-1:0]        sum_ff   [LANES];
   logic [SUM_W-1:0]        sum_in   [LANES];
   logic [FRAC_W-1:0]       mean_ff  [LANES];
   logic [FRAC_W-1:0]       mean_in  [LANES];
   logic [BLEND_W-1:0]      numer_ff [LANES];
   logic [BLEND_W-1:0]      numer_in [LANES];
   logic [FRAC_W-1:0]       fused_ff [LANES];
   logic [FRAC_W-1:0]       fused_in [LANES];
   logic [QUOT_W-1:0]       mq       [LANES];
   logic [HSUM_W-1:0]       hsum_ff, hsum_in;
   logic [WSUM_W-1:0]       wsum_ff, wsum_in;
   logic signed [ATT_W-1:0] att0_ff, att0_in;
   logic [ORIGIN_W-1:0]     origin_ff, origin_in;
   logic [QUOT_W-1:0]       oq;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]      rsp_n_ff, rsp_n_in;
   logic [ORIGIN_W-1:0]     rsp_origin_ff, rsp_origin_in;
   logic signed [ATT_W-1:0] rsp_att_ff, rsp_att_in;
   logic [FRAC_W-1:0]       rsp_fused_ff [LANES];
   logic [FRAC_W-1:0]       rsp_fused_in [LANES];
   logic [FRAC_W-1:0]       rsp_mean_ff  [LANES];
   logic [FRAC_W-1:0]       rsp_mean_in  [LANES];

   logic                    tab_we, start_meas, acc_en, div_start, div_step;
   logic                    numer_en, scale_en, out_load;
   logic [IDX_W-1:0]        widx, ridx;
   logic [WEIGHT_W-1:0]     weight;
   logic [PROD_W-1:0]       prod;
   logic [SCALE_W-1:0]      scaled;
   logic [FRAC_W-1:0]       scaled_q;
   logic [DEN_MEAN_W-1:0]   mean_den;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_item.kind == KIND_MEAS) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (cnt_ff == n_ff) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (step_ff == STEP_W'(QUOT_W - 1)) begin
               state_in = ST_NUMER;
            end
         end
         ST_NUMER: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (lane_ff == LANE_W'(LANES - 1)) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || pop) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // FSM outputs
   always_comb begin
      q_pop     = 1'b0;
      tab_we    = 1'b0;
      start_meas = 1'b0;
      acc_en    = 1'b0;
      div_start = 1'b0;
      div_step  = 1'b0;
      numer_en  = 1'b0;
      scale_en  = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop      = q_valid;
            tab_we     = q_valid && q_item.kind == KIND_PEER &&
                         int'(q_item.slot) < MAX_PEERS;
            start_meas = q_valid && q_item.kind == KIND_MEAS;
         end
         ST_WALK: begin
            acc_en    = (cnt_ff != n_ff);
            div_start = (cnt_ff == n_ff);
         end
         ST_DIVIDE: begin
            div_step = 1'b1;
         end
         ST_NUMER: begin
            numer_en = 1'b1;
         end
         ST_SCALE: begin
            scale_en = 1'b1;
         end
         ST_OUTPUT: begin
            out_load = !rsp_valid_ff || pop;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // peer table
   assign widx = IDX_W'(q_item.slot);

   always_comb begin
      tab_frac_in = tab_frac_ff;
      tab_att_in  = tab_att_ff;
      tab_hgt_in  = tab_hgt_ff;
      if (tab_we) begin
         tab_frac_in[widx] = q_item.frac;
         tab_att_in[widx]  = q_item.att;
         tab_hgt_in[widx]  = q_item.height;
      end
   end

   // peer walk
   always_comb begin
      n_calc = peers_in_use;
      if (int'(peers_in_use) > MAX_PEERS) begin
         n_calc = COUNT_W'(MAX_PEERS);
      end
   end

   assign ridx   = cnt_ff[IDX_W-1:0];
   assign weight = HALF_Q15 + WEIGHT_W'(tab_frac_ff[ridx][0]) +
                   WEIGHT_W'(tab_frac_ff[ridx][1]);
   assign prod   = PROD_W'(weight) * PROD_W'(tab_hgt_ff[ridx]);

   always_comb begin
      n_in    = n_ff;
      cnt_in  = cnt_ff;
      hsum_in = hsum_ff;
      wsum_in = wsum_ff;
      att0_in = att0_ff;
      loc_in  = loc_ff;
      sum_in  = sum_ff;
      if (start_meas) begin
         n_in    = n_calc;
         cnt_in  = '0;
         hsum_in = '0;
         wsum_in = '0;
         att0_in = (n_calc != '0) ? tab_att_ff[0] : '0;
         for (int l = 0; l < LANES; l++) begin
            loc_in[l] = q_item.frac[l];
            sum_in[l] = SUM_W'(q_item.frac[l]);
         end
      end else if (acc_en) begin
         cnt_in  = cnt_ff + 1'b1;
         hsum_in = hsum_ff + HSUM_W'(prod);
         wsum_in = wsum_ff + WSUM_W'(weight);
         for (int l = 0; l < LANES; l++) begin
            sum_in[l] = sum_ff[l] + SUM_W'(tab_frac_ff[ridx][l]);
         end
      end
   end

   // division
   assign mean_den = DEN_MEAN_W'(n_ff) + DEN_MEAN_W'(1);
   assign step_in  = div_start ? '0 : (div_step ? step_ff + 1'b1 : step_ff);

   for (genvar g = 0; g < LANES; g++) begin : g_mean_div
      pcf_div #(
         .NUM_W (SUM_W),
         .DEN_W (DEN_MEAN_W)
      ) u_div (
         .clock (clock),
         .start (div_start),
         .step  (div_step),
         .numer (sum_ff[g]),
         .denom (mean_den),
         .quot  (mq[g])
      );
   end

   pcf_div #(
      .NUM_W (HSUM_W),
      .DEN_W (WSUM_W)
   ) u_origin_div (
      .clock (clock),
      .start (div_start),
      .step  (div_step),
      .numer (hsum_ff),
      .denom (wsum_ff),
      .quot  (oq)
   );

   // blend
   assign scaled   = SCALE_W'(numer_ff[lane_ff]) * SCALE_W'(RECIP_100);
   assign scaled_q = scaled[RECIP_SHIFT +: FRAC_W];
   assign lane_in  = numer_en ? '0 : (scale_en ? lane_ff + 1'b1 : lane_ff);

   always_comb begin
      mean_in   = mean_ff;
      numer_in  = numer_ff;
      fused_in  = fused_ff;
      origin_in = origin_ff;
      if (numer_en) begin
         for (int l = 0; l < LANES; l++) begin
            mean_in[l]  = mq[l];
            numer_in[l] = BLEND_W'(PCT_LOCAL[l]) * BLEND_W'(loc_ff[l]) +
                          BLEND_W'(PCT_TOTAL - PCT_LOCAL[l]) * BLEND_W'(mq[l]);
         end
         if (n_ff == '0) begin
            origin_in = '0;
         end else if (oq > QUOT_W'(ORIGIN_MAX_MM)) begin
            origin_in = ORIGIN_MAX_MM;
         end else begin
            origin_in = oq[ORIGIN_W-1:0];
         end
      end
      if (scale_en) begin
         fused_in[lane_ff] = sat_frac(scaled_q);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_n_in      = rsp_n_ff;
      rsp_origin_in = rsp_origin_ff;
      rsp_att_in    = rsp_att_ff;
      rsp_fused_in  = rsp_fused_ff;
      rsp_mean_in   = rsp_mean_ff;
      if (pop) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_n_in      = n_ff;
         rsp_origin_in = origin_ff;
         rsp_att_in    = att0_ff;
         rsp_fused_in  = fused_ff;
         rsp_mean_in   = mean_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_PEERS; i++) begin
            tab_frac_ff[i] <= '0;
            tab_att_ff[i]  <= '0;
            tab_hgt_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tab_frac_ff  <= tab_frac_in;
         tab_att_ff   <= tab_att_in;
         tab_hgt_ff   <= tab_hgt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      cnt_ff        <= cnt_in;
      step_ff       <= step_in;
      lane_ff       <= lane_in;
      loc_ff        <= loc_in;
      sum_ff        <= sum_in;
      hsum_ff       <= hsum_in;
      wsum_ff       <= wsum_in;
      att0_ff       <= att0_in;
      mean_ff       <= mean_in;
      numer_ff      <= numer_in;
      fused_ff      <= fused_in;
      origin_ff     <= origin_in;
      rsp_n_ff      <= rsp_n_in;
      rsp_origin_ff <= rsp_origin_in;
      rsp_att_ff    <= rsp_att_in;
      rsp_fused_ff  <= rsp_fused_in;
      rsp_mean_ff   <= rsp_mean_in;
   end

   assign empty                      = ~rsp_valid_ff;
   assign rsp_peers_used             = rsp_n_ff;
   assign rsp_origin_mm              = rsp_origin_ff;
   assign rsp_first_peer_attenuation = rsp_att_ff;
   assign rsp_fused_leak             = rsp_fused_ff[0];
   assign rsp_fused_spread           = rsp_fused_ff[1];
   assign rsp_fused_confidence       = rsp_fused_ff[2];
   assign rsp_mean_leak              = rsp_mean_ff[0];
   assign rsp_mean_spread            = rsp_mean_ff[1];
   assign rsp_mean_confidence        = rsp_mean_ff[2];

endmodule

// File: rtl/core/peer_consensus_fusion.sv
// ----------------------------------------------------------------------------
// peer_consensus_fusion
// Fuses a local reading with a table of peer reports.
// A measurement walks n peers, one per cycle (n = peers used), then takes
// 16 serial divide steps and blends; a result waits until the last is popped.
// Measurements go one at a time; peer reports apply one per cycle when idle.
// Reset: peer table cleared to zero, peers_in_use = 4, queues empty.
// ----------------------------------------------------------------------------
module peer_consensus_fusion #(
   parameter int MAX_PEERS = pcf_pkg::MAX_PEERS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_kind,
   input  logic [pcf_pkg::SLOT_W-1:0]          req_slot,
   input  logic [pcf_pkg::FRAC_W-1:0]          req_leak_level,
   input  logic [pcf_pkg::FRAC_W-1:0]          req_spread_level,
   input  logic [pcf_pkg::FRAC_W-1:0]          req_confidence_level,
   input  logic signed [pcf_pkg::ATT_W-1:0]    req_attenuation,
   input  logic [pcf_pkg::HEIGHT_W-1:0]        req_height_mm,
   output logic                                empty,
   input  logic                                pop,
   output logic [pcf_pkg::COUNT_W-1:0]         rsp_peers_used,
   output logic [pcf_pkg::ORIGIN_W-1:0]        rsp_origin_mm,
   output logic signed [pcf_pkg::ATT_W-1:0]    rsp_first_peer_attenuation,
   output logic [pcf_pkg::FRAC_W-1:0]          rsp_fused_leak,
   output logic [pcf_pkg::FRAC_W-1:0]          rsp_fused_spread,
   output logic [pcf_pkg::FRAC_W-1:0]          rsp_fused_confidence,
   output logic [pcf_pkg::FRAC_W-1:0]          rsp_mean_leak,
   output logic [pcf_pkg::FRAC_W-1:0]          rsp_mean_spread,
   output logic [pcf_pkg::FRAC_W-1:0]          rsp_mean_confidence,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pcf_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import pcf_pkg::*;

   item_type           q_item;
   logic               q_valid, q_pop;
   logic [COUNT_W-1:0] peers_in_use_ff, peers_in_use_in;
   logic               csr_hit, csr_wr;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == CSR_PEERS_IN_USE);
   assign csr_wr  = psel & penable & pwrite & pready;
   assign prdata  = csr_hit ? {{(32-COUNT_W){1'b0}}, peers_in_use_ff} : '0;

   assign peers_in_use_in = (csr_wr && csr_hit) ? pwdata[COUNT_W-1:0] : peers_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         peers_in_use_ff <= PEERS_IN_USE_RST;
      end else begin
         peers_in_use_ff <= peers_in_use_in;
      end
   end

   pcf_front u_front (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_kind             (req_kind),
      .req_slot             (req_slot),
      .req_leak_level       (req_leak_level),
      .req_spread_level     (req_spread_level),
      .req_confidence_level (req_confidence_level),
      .req_attenuation      (req_attenuation),
      .req_height_mm        (req_height_mm),
      .q_item               (q_item),
      .q_valid              (q_valid),
      .q_pop                (q_pop)
   );

   pcf_back #(
      .MAX_PEERS (MAX_PEERS)
   ) u_back (
      .clock                      (clock),
      .reset                      (reset),
      .q_item                     (q_item),
      .q_valid                    (q_valid),
      .q_pop                      (q_pop),
      .peers_in_use               (peers_in_use_ff),
      .pop                        (pop),
      .empty                      (empty),
      .rsp_peers_used             (rsp_peers_used),
      .rsp_origin_mm              (rsp_origin_mm),
      .rsp_first_peer_attenuation (rsp_first_peer_attenuation),
      .rsp_fused_leak             (rsp_fused_leak),
      .rsp_fused_spread           (rsp_fused_spread),
      .rsp_fused_confidence       (rsp_fused_confidence),
      .rsp_mean_leak              (rsp_mean_leak),
      .rsp_mean_spread            (rsp_mean_spread),
      .rsp_mean_confidence        (rsp_mean_confidence)
   );

endmodule

// File: tb/fusion_monitor.sv
// ----------------------------------------------------------------------------
// fusion_monitor
// Watches the request, result and register ports of peer_consensus_fusion,
// keeps its own copy of the peer table and peer count, computes the fused
// result of every accepted measurement beat and compares it, field by field,
// with the result beats popped from the block.
// ----------------------------------------------------------------------------
module fusion_monitor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic                                full,
   input  logic                                req_kind,
   input  logic [pcf_pkg::SLOT_W-1:0]          req_slot,
   input  logic [pcf_pkg::FRAC_W-1:0]          req_leak_level,
   input  logic [pcf_pkg::FRAC_W-1:0]          req_spread_level,
   input  logic [pcf_pkg::FRAC_W-1:0]          req_confidence_level,
   input  logic signed [pcf_pkg::ATT_W-1:0]    req_attenuation,
   input  logic [pcf_pkg::HEIGHT_W-1:0]        req_height_mm,
   input  logic                                empty,
   input  logic                                pop,
   input  logic [pcf_pkg::COUNT_W-1:0]         rsp_peers_used,
   input  logic [pcf_pkg::ORIGIN_W-1:0]        rsp_origin_mm,
   input  logic signed [pcf_pkg::ATT_W-1:0]    rsp_first_peer_attenuation,
   input  logic [pcf_pkg::FRAC_W-1:0]          rsp_fused_leak,
   input  logic [pcf_pkg::FRAC_W-1:0]          rsp_fused_spread,
   input  logic [pcf_pkg::FRAC_W-1:0]          rsp_fused_confidence,
   input  logic [pcf_pkg::FRAC_W-1:0]          rsp_mean_leak,
   input  logic [pcf_pkg::FRAC_W-1:0]          rsp_mean_spread,
   input  logic [pcf_pkg::FRAC_W-1:0]          rsp_mean_confidence,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pcf_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   input  logic [31:0]                         prdata,
   input  logic                                pready,
   output int                                  fail_count,
   output int                                  pending_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import pcf_pkg::*;

   localparam int TABLE_DEPTH = MAX_PEERS_DEF;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PEERS = {CSR_PEERS_IN_USE, 2'b00};

   typedef struct {
      logic [COUNT_W-1:0]      peers_used;
      logic [ORIGIN_W-1:0]     origin_mm;
      logic signed [ATT_W-1:0] first_att;
      logic [FRAC_W-1:0]       fused_leak;
      logic [FRAC_W-1:0]       fused_spread;
      logic [FRAC_W-1:0]       fused_conf;
      logic [FRAC_W-1:0]       mean_leak;
      logic [FRAC_W-1:0]       mean_spread;
      logic [FRAC_W-1:0]       mean_conf;
   } fusion_type;

   logic [FRAC_W-1:0]       tbl_leak   [TABLE_DEPTH];
   logic [FRAC_W-1:0]       tbl_spread [TABLE_DEPTH];
   logic [FRAC_W-1:0]       tbl_conf   [TABLE_DEPTH];
   logic signed [ATT_W-1:0] tbl_att    [TABLE_DEPTH];
   logic [HEIGHT_W-1:0]     tbl_height [TABLE_DEPTH];
   logic [COUNT_W-1:0]      peers_cfg;
   fusion_type              fusion_expected_q[$];
   int                      errs = 0;

   function automatic logic [FRAC_W-1:0] clip_q15(input longint unsigned v);
      return (v > 32768) ? FRAC_W'(32768) : FRAC_W'(v);
   endfunction

   function automatic logic [FRAC_W-1:0] mix_q15(input logic [FRAC_W-1:0] loc,
                                                 input logic [FRAC_W-1:0] avg,
                                                 input int unsigned pct);
      longint unsigned v;
      v = (longint'(pct) * loc + longint'(100 - pct) * avg) / 100;
      return clip_q15(v);
   endfunction

   function automatic fusion_type fuse_measurement(input logic [FRAC_W-1:0] l,
                                                   input logic [FRAC_W-1:0] s,
                                                   input logic [FRAC_W-1:0] c);
      fusion_type      r;
      int unsigned     n;
      longint unsigned lsum, ssum, csum, wsum, hsum, w, org;
      n    = (peers_cfg < TABLE_DEPTH) ? peers_cfg : TABLE_DEPTH;
      lsum = l;
      ssum = s;
      csum = c;
      wsum = 0;
      hsum = 0;
      org  = 0;
      for (int unsigned i = 0; i < n; i++) begin
         w    = 16384 + longint'(tbl_leak[i]) + tbl_spread[i];
         lsum += tbl_leak[i];
         ssum += tbl_spread[i];
         csum += tbl_conf[i];
         hsum += w * tbl_height[i];
         wsum += w;
      end
      if (wsum != 0) org = hsum / wsum;
      if (org > 2000) org = 2000;
      r.peers_used   = COUNT_W'(n);
      r.origin_mm    = ORIGIN_W'(org);
      r.first_att    = (n != 0) ? tbl_att[0] : '0;
      r.mean_leak    = FRAC_W'(lsum / (n + 1));
      r.mean_spread  = FRAC_W'(ssum / (n + 1));
      r.mean_conf    = FRAC_W'(csum / (n + 1));
      r.fused_leak   = mix_q15(l, r.mean_leak, 62);
      r.fused_spread = mix_q15(s, r.mean_spread, 60);
      r.fused_conf   = mix_q15(c, r.mean_conf, 55);
      return r;
   endfunction

   task automatic check_field(input string name, input longint exp, input longint act);
      if (exp != act) begin
         errs++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      end
   endtask

   task automatic check_result_beat();
      fusion_type e;
      if (fusion_expected_q.size() == 0) begin
         errs++;
         $display("%0t: result beat with nothing expected", $time);
      end else begin
         e = fusion_expected_q.pop_front();
         check_field("peers_used", e.peers_used, rsp_peers_used);
         check_field("origin_mm", e.origin_mm, rsp_origin_mm);
         check_field("first_peer_attenuation", e.first_att, rsp_first_peer_attenuation);
         check_field("fused_leak", e.fused_leak, rsp_fused_leak);
         check_field("fused_spread", e.fused_spread, rsp_fused_spread);
         check_field("fused_confidence", e.fused_conf, rsp_fused_confidence);
         check_field("mean_leak", e.mean_leak, rsp_mean_leak);
         check_field("mean_spread", e.mean_spread, rsp_mean_spread);
         check_field("mean_confidence", e.mean_conf, rsp_mean_confidence);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_leak[i]   = '0;
            tbl_spread[i] = '0;
            tbl_conf[i]   = '0;
            tbl_att[i]    = '0;
            tbl_height[i] = '0;
         end
         peers_cfg = PEERS_IN_USE_RST;
         fusion_expected_q.delete();
      end else begin
         if (!empty && pop) check_result_beat();
         if (push && !full) begin
            if (req_kind == KIND_MEAS) begin
               fusion_expected_q.push_back(fuse_measurement(clip_q15(req_leak_level),
                                                            clip_q15(req_spread_level),
                                                            clip_q15(req_confidence_level)));
            end else if (req_slot < TABLE_DEPTH) begin
               tbl_leak[req_slot]   = clip_q15(req_leak_level);
               tbl_spread[req_slot] = clip_q15(req_spread_level);
               tbl_conf[req_slot]   = clip_q15(req_confidence_level);
               tbl_att[req_slot]    = req_attenuation;
               tbl_height[req_slot] = req_height_mm;
            end
         end
         if (psel && penable && pready && paddr == ADDR_PEERS) begin
            if (pwrite) begin
               peers_cfg = pwdata[COUNT_W-1:0];
            end else begin
               check_field("peers_in_use readback", {28'd0, peers_cfg}, prdata);
            end
         end
      end
      pending_results <= fusion_expected_q.size();
      fail_count      <= errs;
   end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for peer_consensus_fusion: directed peer reports and measurements
// at the field extremes, then random beats over several peer counts and three
// idling profiles, with a long result hold-off and a drain pause. Checking is
// done by fusion_monitor; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcf_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_PEERS = {CSR_PEERS_IN_USE, 2'b00};
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 400;
   localparam int SEG_ITEMS     = 66;

   bit clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic req_kind = 1'b0;
   logic [SLOT_W-1:0] req_slot = '0;
   logic [FRAC_W-1:0] req_leak_level = '0;
   logic [FRAC_W-1:0] req_spread_level = '0;
   logic [FRAC_W-1:0] req_confidence_level = '0;
   logic signed [ATT_W-1:0] req_attenuation = '0;
   logic [HEIGHT_W-1:0] req_height_mm = '0;
   logic empty;
   logic pop = 1'b0;
   logic [COUNT_W-1:0] rsp_peers_used;
   logic [ORIGIN_W-1:0] rsp_origin_mm;
   logic signed [ATT_W-1:0] rsp_first_peer_attenuation;
   logic [FRAC_W-1:0] rsp_fused_leak, rsp_fused_spread, rsp_fused_confidence;
   logic [FRAC_W-1:0] rsp_mean_leak, rsp_mean_spread, rsp_mean_confidence;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   int fail_count;
   int pending_results;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   always #5 clock = ~clock;

   peer_consensus_fusion uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_kind(req_kind), .req_slot(req_slot),
      .req_leak_level(req_leak_level), .req_spread_level(req_spread_level),
      .req_confidence_level(req_confidence_level),
      .req_attenuation(req_attenuation), .req_height_mm(req_height_mm),
      .empty(empty), .pop(pop),
      .rsp_peers_used(rsp_peers_used), .rsp_origin_mm(rsp_origin_mm),
      .rsp_first_peer_attenuation(rsp_first_peer_attenuation),
      .rsp_fused_leak(rsp_fused_leak), .rsp_fused_spread(rsp_fused_spread),
      .rsp_fused_confidence(rsp_fused_confidence),
      .rsp_mean_leak(rsp_mean_leak), .rsp_mean_spread(rsp_mean_spread),
      .rsp_mean_confidence(rsp_mean_confidence),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   fusion_monitor monitor (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_kind(req_kind), .req_slot(req_slot),
      .req_leak_level(req_leak_level), .req_spread_level(req_spread_level),
      .req_confidence_level(req_confidence_level),
      .req_attenuation(req_attenuation), .req_height_mm(req_height_mm),
      .empty(empty), .pop(pop),
      .rsp_peers_used(rsp_peers_used), .rsp_origin_mm(rsp_origin_mm),
      .rsp_first_peer_attenuation(rsp_first_peer_attenuation),
      .rsp_fused_leak(rsp_fused_leak), .rsp_fused_spread(rsp_fused_spread),
      .rsp_fused_confidence(rsp_fused_confidence),
      .rsp_mean_leak(rsp_mean_leak), .rsp_mean_spread(rsp_mean_spread),
      .rsp_mean_confidence(rsp_mean_confidence),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .fail_count(fail_count), .pending_results(pending_results)
   );

   // result side: random pop, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         pop         <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else begin
         pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   function automatic logic [FRAC_W-1:0] rand_frac();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return FRAC_W'(32768);
         2: return FRAC_W'($urandom_range(32769, 65535));
         default: return FRAC_W'($urandom_range(0, 32768));
      endcase
   endfunction

   function automatic item_type rand_item();
      item_type it;
      it.kind    = ($urandom_range(0, 99) < 40) ? KIND_MEAS : KIND_PEER;
      it.slot    = SLOT_W'($urandom);
      it.frac[0] = rand_frac();
      it.frac[1] = rand_frac();
      it.frac[2] = rand_frac();
      it.att     = ATT_W'($urandom);
      it.height  = ($urandom_range(0, 7) == 0) ? HEIGHT_W'(4095) : HEIGHT_W'($urandom);
      return it;
   endfunction

   task automatic send_item(input item_type it);
      while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push                 <= 1'b1;
      req_kind             <= it.kind;
      req_slot             <= it.slot;
      req_leak_level       <= it.frac[0];
      req_spread_level     <= it.frac[1];
      req_confidence_level <= it.frac[2];
      req_attenuation      <= it.att;
      req_height_mm        <= it.height;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic send_peer(input int s, input int l, input int sp, input int c,
                            input int a, input int h);
      item_type it;
      it.kind    = KIND_PEER;
      it.slot    = SLOT_W'(s);
      it.frac[0] = FRAC_W'(l);
      it.frac[1] = FRAC_W'(sp);
      it.frac[2] = FRAC_W'(c);
      it.att     = ATT_W'(a);
      it.height  = HEIGHT_W'(h);
      send_item(it);
   endtask

   task automatic send_meas(input int l, input int sp, input int c);
      item_type it;
      it.kind    = KIND_MEAS;
      it.slot    = SLOT_W'($urandom);
      it.frac[0] = FRAC_W'(l);
      it.frac[1] = FRAC_W'(sp);
      it.frac[2] = FRAC_W'(c);
      it.att     = ATT_W'($urandom);
      it.height  = HEIGHT_W'($urandom);
      send_item(it);
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= ADDR_PEERS;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_peers(input int value);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, 32'(value));
      csr_access(1'b0, 32'd0);
   endtask

   int peer_plan[12] = '{0, 8, 15, 1, 4, 12, 2, 7, -1, 8, 0, -1};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table at the reset peer count, then extremes
      send_meas(0, 0, 0);
      send_meas(32768, 32768, 32768);
      send_meas(65535, 40000, 32769);
      send_peer(0, 32768, 32768, 32768, -65536, 4095);
      send_peer(1, 65535, 0, 65535, 65535, 0);
      send_peer(2, 0, 65535, 0, 32768, 4095);
      send_peer(3, 32769, 32769, 1, -32768, 2048);
      send_peer(4, 16384, 100, 30000, -1, 1);
      send_peer(5, 1, 32768, 0, 0, 4094);
      send_peer(6, 32767, 32767, 32767, 1, 4095);
      send_peer(7, 0, 0, 0, 12345, 4095);
      send_meas(32768, 0, 16384);
      set_peers(8);
      send_meas(0, 0, 0);
      send_meas(65535, 65535, 65535);
      set_peers(0);
      send_meas(20000, 30000, 65535);
      send_peer(0, 100, 200, 300, 400, 500);
      send_meas(1, 2, 3);
      set_peers(15);
      send_meas(32768, 32768, 0);
      set_peers(1);
      send_meas(0, 32768, 32768);

      for (int seg = 0; seg < 12; seg++) begin
         case (seg / 4)
            0: begin
               tx_idle_pct = 20;
               rx_idle_pct <= 85;
            end
            1: begin
               tx_idle_pct = 85;
               rx_idle_pct <= 20;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct <= 0;
            end
         endcase
         set_peers((peer_plan[seg] < 0) ? $urandom_range(0, 15) : peer_plan[seg]);
         if (seg == 0 || seg == 9) hold_requests <= hold_requests + 1;
         for (int k = 0; k < SEG_ITEMS; k++) begin
            if (seg == 6 && k == SEG_ITEMS / 2) drain();
            send_item(rand_item());
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/pcf_pkg.sv
rtl/core/pcf_front.sv
rtl/core/pcf_div.sv
rtl/core/pcf_back.sv
rtl/core/peer_consensus_fusion.sv
tb/fusion_monitor.sv
tb/tb.sv
